FILE: src/mtlcg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtlcg_pkg
// Shared types, constants and word functions of the twister generator.
// ----------------------------------------------------------------------------
package mtlcg_pkg;

    localparam int WORD_W         = 32;
    localparam int STATE_WORDS    = 624;
    localparam int TWIST_OFFSET   = 397;
    localparam int SCRAMBLE_STEPS = 50;
    localparam int CNT_W          = 10;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    localparam word_t LCG_MULT      = 32'd69069;
    localparam word_t TWIST_MATRIX  = 32'h9908b0df;
    localparam word_t HIGH_BIT      = 32'h80000000;
    localparam word_t LOW_BITS      = 32'h7fffffff;
    localparam word_t TEMPER_MASK_B = 32'h9d2c5680;
    localparam word_t TEMPER_MASK_C = 32'hefc60000;

    // Last step index of the scramble phase; one extra step covers the
    // dropped first fill value.
    localparam cnt_t SCRAMBLE_LAST = CNT_W'(SCRAMBLE_STEPS);
    localparam cnt_t FILL_LAST     = CNT_W'(STATE_WORDS - 1);

    // Seeding sequencer states
    typedef enum logic [2:0] {
        SEED_SCRAMBLE = 3'b001,
        SEED_FILL     = 3'b010,
        SEED_RUN      = 3'b100
    } seed_state_t;

    // Seeder control toward the chain and the draw logic
    typedef struct packed {
        logic fill_shift;  // shift the fill word into the chain tail
        logic run;         // seeding done, draws allowed
    } seed_ctrl_t;

    // Words tapped from the chain for the recurrence
    typedef struct packed {
        word_t head;       // oldest word
        word_t next;       // word after the head
        word_t mid;        // word at the twist offset
    } chain_taps_t;

    function automatic word_t lcg_next(input word_t x);
        word_t p;
        p = x * LCG_MULT;
        return p + 32'd1;
    endfunction

    function automatic word_t twist(input word_t w0, input word_t w1, input word_t wm);
        word_t y;
        word_t v;
        y = (w0 & HIGH_BIT) | (w1 & LOW_BITS);
        v = wm ^ (y >> 1);
        if (y[0])
        begin
            v = v ^ TWIST_MATRIX;
        end
        return v;
    endfunction

    function automatic word_t temper(input word_t y);
        word_t t;
        t = y ^ (y >> 11);
        t = t ^ ((t << 7) & TEMPER_MASK_B);
        t = t ^ ((t << 15) & TEMPER_MASK_C);
        t = t ^ (t >> 18);
        return t;
    endfunction

endpackage

FILE: src/mtlcg_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtlcg_cell
// One state word of the twister; loads its neighbor's word on a shift.
// ----------------------------------------------------------------------------
module mtlcg_cell
(
    input  logic             clk,
    input  logic             shift_en,
    input  mtlcg_pkg::word_t d,
    output mtlcg_pkg::word_t q
);
    import mtlcg_pkg::*;

    word_t word_reg;

    // Take the neighbor's word on each shift
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            word_reg <= d;
        end
    end

    assign q = word_reg;

endmodule

FILE: src/mtlcg_chain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtlcg_chain
// Row of state cells; words move toward the head, new words enter the tail.
// ----------------------------------------------------------------------------
module mtlcg_chain
(
    input  logic                    clk,
    input  logic                    shift_en,
    input  mtlcg_pkg::word_t        tail_word,
    output mtlcg_pkg::chain_taps_t  taps
);
    import mtlcg_pkg::*;

    word_t cell_q [STATE_WORDS];

    // Build the row, each cell fed by the one behind it
    for (genvar i = 0; i < STATE_WORDS; i++)
    begin : g_cell
        word_t cell_d;
        if (i == STATE_WORDS - 1)
        begin : g_tail
            assign cell_d = tail_word;
        end
        else
        begin : g_body
            assign cell_d = cell_q[i+1];
        end
        mtlcg_cell u_cell
        (
            .clk      (clk),
            .shift_en (shift_en),
            .d        (cell_d),
            .q        (cell_q[i])
        );
    end

    // Tap the recurrence inputs
    assign taps.head = cell_q[0];
    assign taps.next = cell_q[1];
    assign taps.mid  = cell_q[TWIST_OFFSET];

endmodule

FILE: src/mtlcg_seeder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtlcg_seeder
// LCG scrambler and sequencer that refills the chain from the seed.
// ----------------------------------------------------------------------------
module mtlcg_seeder
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   seed_wr,
    input  mtlcg_pkg::word_t       seed,
    output mtlcg_pkg::seed_ctrl_t  ctrl,
    output mtlcg_pkg::word_t       fill_word
);
    import mtlcg_pkg::*;

    seed_state_t state_reg, state_next;
    cnt_t        cnt_reg, cnt_next;
    word_t       lcg_reg, lcg_next_val;
    word_t       lcg_step;

    assign lcg_step = lcg_next(lcg_reg);

    // Sequence scramble, fill and run
    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        lcg_next_val = lcg_reg;
        case (state_reg)
            SEED_SCRAMBLE:
            begin
                lcg_next_val = lcg_step;
                if (cnt_reg == SCRAMBLE_LAST)
                begin
                    cnt_next   = '0;
                    state_next = SEED_FILL;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            SEED_FILL:
            begin
                lcg_next_val = lcg_step;
                if (cnt_reg == FILL_LAST)
                begin
                    cnt_next   = '0;
                    state_next = SEED_RUN;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            SEED_RUN:
            begin
                cnt_next = '0;
            end
            default:
            begin
                state_next = SEED_SCRAMBLE;
                cnt_next   = '0;
            end
        endcase
        // Restart from a new seed
        if (seed_wr)
        begin
            state_next   = SEED_SCRAMBLE;
            cnt_next     = '0;
            lcg_next_val = seed;
        end
    end

    // Hold sequencer state and LCG value
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SEED_SCRAMBLE;
            cnt_reg   <= '0;
            lcg_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            lcg_reg   <= lcg_next_val;
        end
    end

    assign ctrl.fill_shift = (state_reg == SEED_FILL);
    assign ctrl.run        = (state_reg == SEED_RUN);
    assign fill_word       = lcg_step;

endmodule

FILE: src/mt19937_lcg_seeded_generator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mt19937_lcg_seeded_generator_top
// MT19937 generator with LCG seeding, state held in a shifting cell row.
// ----------------------------------------------------------------------------
//  Channel  Direction  Signals                          Content
//  s_*      in         s_tvalid s_tready s_tdata[7:0]   draw request
//  m_*      out        m_tvalid m_tready m_tdata[31:0]  tempered random word
//  cfg_*    in         cfg_valid cfg_ready cfg_data     seed register
//
//  One draw request per cycle while s_tready is high; its word is
//  registered in the output register, or in the second buffer entry
//  if the output register is full. Twist and tempering are combinational.
//  After reset and each seed write, seeding runs 51 LCG steps, then 624
//  fill shifts into the cell row, s_tready low. A two-entry output buffer
//  takes draws while m_tready is low; s_tready drops when both are full.
// ----------------------------------------------------------------------------
module mt19937_lcg_seeded_generator_top
(
    input  logic        clk,
    input  logic        rst_n,
    // Draw requests: bit 0 draw_request, bits 7:1 zero
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,
    // Results: bits 31:0 random_word
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,
    // Seed writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);
    import mtlcg_pkg::*;

    seed_ctrl_t  ctrl;
    chain_taps_t taps;
    word_t       fill_word;
    word_t       new_word;
    word_t       tail_word;
    logic        seed_wr;
    logic        draw;
    logic        pop;
    logic        shift_en;

    word_t out_reg;
    logic  out_valid_reg;
    word_t skid_reg;
    logic  skid_valid_reg;

    assign cfg_ready = 1'b1;
    assign seed_wr   = cfg_valid && cfg_ready;

    mtlcg_seeder u_seeder
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .seed_wr   (seed_wr),
        .seed      (cfg_data),
        .ctrl      (ctrl),
        .fill_word (fill_word)
    );

    // Accept draws once seeded and buffer space remains
    assign s_tready = ctrl.run && !skid_valid_reg;
    assign draw     = s_tvalid && s_tready && s_tdata[0];
    assign pop      = m_tvalid && m_tready;

    // Next twister word from the three taps
    assign new_word  = twist(taps.head, taps.next, taps.mid);
    assign tail_word = ctrl.fill_shift ? fill_word : new_word;
    assign shift_en  = ctrl.fill_shift || draw;

    mtlcg_chain u_chain
    (
        .clk       (clk),
        .shift_en  (shift_en),
        .tail_word (tail_word),
        .taps      (taps)
    );

    // Output buffer valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= draw;
            end
        end
        else if (draw)
        begin
            if (out_valid_reg)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    // Output buffer words
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
            end
            else if (draw)
            begin
                out_reg <= temper(new_word);
            end
        end
        else if (draw)
        begin
            if (out_valid_reg)
            begin
                skid_reg <= temper(new_word);
            end
            else
            begin
                out_reg <= temper(new_word);
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the LCG-seeded MT19937 word generator.
// Draw requests enter on the slave stream and seeds on the config channel.
// A local twister model predicts every tempered word. Each word on the
// master stream is compared in order, with random gaps on the request side
// and random stalls on the result side.
// ----------------------------------------------------------------------------
module tb;
    import mtlcg_pkg::*;

    localparam int CLK_PERIOD  = 20;
    localparam int CYCLE_LIMIT = 500000;
    localparam int TAIL_CYCLES = 8;
    localparam int REPORT_MAX  = 10;

    // Model constants are local; STATE_WORDS and TWIST_OFFSET are imported
    localparam word_t SCRAMBLE_MUL    = 32'd69069;
    localparam int    SCRAMBLE_ROUNDS = 50;
    localparam word_t MATRIX_A        = 32'h9908b0df;
    localparam word_t UPPER_MASK      = 32'h80000000;
    localparam word_t LOWER_MASK      = 32'h7fffffff;
    localparam word_t TEMPER_B        = 32'h9d2c5680;
    localparam word_t TEMPER_C        = 32'hefc60000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // bit 0 draw_request, bits 7:1 zero
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // bits 31:0 random_word
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] cfg_data;

    // Model state
    word_t mt_words [STATE_WORDS];
    int    mt_pos;
    word_t expected_words [$];

    int error_count  = 0;
    int cycle_count  = 0;
    int hold_cycles  = 0;
    bit send_idle_on = 1'b0;
    bit recv_idle_on = 1'b0;

    mt19937_lcg_seeded_generator_top u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Twister model
    // ------------------------------------------------------------------------
    function automatic word_t scramble(input word_t x);
        return x * SCRAMBLE_MUL + 32'd1;
    endfunction

    // Scramble the seed, drop one value, fill the state words
    function automatic void reseed_model(input word_t seed_value);
        word_t x;
        int    j;
        x = seed_value;
        for (j = 0; j < SCRAMBLE_ROUNDS + 1; j++)
            x = scramble(x);
        for (j = 0; j < STATE_WORDS; j++)
        begin
            x = scramble(x);
            mt_words[j] = x;
        end
        mt_pos = STATE_WORDS;
    endfunction

    // Regenerate the whole block in place
    function automatic void twist_block();
        word_t y;
        word_t v;
        int    k;
        for (k = 0; k < STATE_WORDS; k++)
        begin
            y = (mt_words[k] & UPPER_MASK) | (mt_words[(k + 1) % STATE_WORDS] & LOWER_MASK);
            v = mt_words[(k + TWIST_OFFSET) % STATE_WORDS] ^ (y >> 1);
            if (y[0])
                v = v ^ MATRIX_A;
            mt_words[k] = v;
        end
        mt_pos = 0;
    endfunction

    function automatic word_t next_tempered_word();
        word_t t;
        if (mt_pos >= STATE_WORDS)
            twist_block();
        t = mt_words[mt_pos];
        mt_pos++;
        t = t ^ (t >> 11);
        t = t ^ ((t << 7) & TEMPER_B);
        t = t ^ ((t << 15) & TEMPER_C);
        t = t ^ (t >> 18);
        return t;
    endfunction

    // ------------------------------------------------------------------------
    // Shared driving tasks
    // ------------------------------------------------------------------------
    // Offer one request, optionally after a gap, and predict its word
    task automatic send_request(input logic draw);
        if (send_idle_on && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, draw};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (draw)
            expected_words.push_back(next_tempered_word());
    endtask

    // Drop valid and wait until every predicted word has come out
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic write_seed(input word_t value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        reseed_model(value);
    endtask

    // Random requests, mostly draws, until the draw count is reached
    task automatic run_draws(input int draw_total, input bit mix_idle);
        int   draws;
        int   items;
        logic draw;
        draws = 0;
        items = 0;
        while (draws < draw_total)
        begin
            if (mix_idle && items % 50 == 0)
            begin
                send_idle_on = ($urandom_range(0, 2) != 0);
                recv_idle_on = ($urandom_range(0, 2) != 0);
            end
            draw = ($urandom_range(0, 7) != 0);
            send_request(draw);
            if (draw)
                draws++;
            items++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Words from the reset seed, with empty requests mixed in
    task automatic test_reset_seed();
        send_idle_on = 1'b0;
        recv_idle_on = 1'b0;
        send_request(1'b0);
        send_request(1'b1);
        send_request(1'b1);
        send_request(1'b1);
        send_request(1'b0);
        send_request(1'b1);
        send_request(1'b1);
    endtask

    // Extreme seeds, and a reseed with zero restarting the reset sequence
    task automatic test_seed_extremes();
        write_seed(32'hffffffff);
        send_request(1'b1);
        send_request(1'b1);
        send_request(1'b0);
        send_request(1'b1);
        write_seed(32'h00000000);
        send_request(1'b1);
        send_request(1'b1);
        send_request(1'b1);
        write_seed(32'h80000000);
        send_request(1'b1);
        send_request(1'b1);
        write_seed(32'h00000001);
        send_request(1'b1);
        send_request(1'b1);
    endtask

    // Run past the end of the first block so the twist is exercised
    task automatic test_block_regen();
        write_seed($urandom);
        run_draws(640, 1'b1);
    endtask

    // Hold the result side off while requests keep coming
    task automatic test_output_stall();
        send_idle_on = 1'b0;
        recv_idle_on = 1'b0;
        hold_cycles  = 300;
        repeat (40) send_request(1'b1);
    endtask

    // Short phases, each under a fresh seed, reseeding mid-block
    task automatic test_random_mix();
        int phase;
        for (phase = 0; phase < 4; phase++)
        begin
            write_seed($urandom);
            run_draws($urandom_range(40, 120), 1'b1);
        end
    endtask

    // Back-to-back requests, mostly draws, across a block boundary, no idling
    task automatic test_full_rate();
        send_idle_on = 1'b0;
        recv_idle_on = 1'b0;
        write_seed($urandom);
        run_draws(640, 1'b0);
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stalls and the long hold-off
    // ------------------------------------------------------------------------
    initial
    begin : receiver
        int gap;
        m_tready = 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_cycles != 0)
            begin
                m_tready <= 1'b0;
                gap = hold_cycles;
                hold_cycles = 0;
                repeat (gap) @(posedge clk);
            end
            else if (recv_idle_on && $urandom_range(0, 7) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
        end
    end

    // Compare each accepted word with the oldest prediction
    always @(posedge clk)
    begin : check_words
        word_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_words.size() == 0)
            begin
                error_count++;
                if (error_count <= REPORT_MAX)
                    $display("unexpected word: actual %h", m_tdata);
            end
            else
            begin
                want = expected_words.pop_front();
                if (m_tdata !== want)
                begin
                    error_count++;
                    if (error_count <= REPORT_MAX)
                        $display("random_word mismatch: expected %h actual %h", want, m_tdata);
                end
            end
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    initial
    begin : stimulus
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = 8'd0;
        cfg_valid = 1'b0;
        cfg_data  = 32'd0;
        reseed_model(32'd0);
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_seed();
        test_seed_extremes();
        test_block_regen();
        test_output_stall();
        test_random_mix();
        test_full_rate();
        drain_results();

        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
